// File: rtl/kmeans_cluster_assign_core_defines.svh
// ---------------------------------------------------------------------------
// kmeans cluster assign assertion macros
// shared property forms for the assertions in kca_ctrl.sv
// ---------------------------------------------------------------------------
`ifndef KMEANS_CLUSTER_ASSIGN_CORE_DEFINES_SVH
`define KMEANS_CLUSTER_ASSIGN_CORE_DEFINES_SVH

// same-cycle implication
`define KCA_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define KCA_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/kca_pkg.sv
// ---------------------------------------------------------------------------
// kca_pkg
// types, constants and command codes of the kmeans cluster assign core
// ---------------------------------------------------------------------------
`default_nettype none

package kca_pkg;

    localparam int MAX_ROWS     = 64;
    localparam int MAX_COLS     = 16;
    localparam int MAX_CLUSTERS = 8;
    localparam int STORE_DEPTH  = MAX_ROWS * MAX_COLS;
    localparam int CEN_DEPTH    = MAX_CLUSTERS * MAX_COLS;

    localparam int ROW_W   = $clog2(MAX_ROWS);
    localparam int COL_W   = $clog2(MAX_COLS);
    localparam int CL_W    = $clog2(MAX_CLUSTERS);
    localparam int ADDR_W  = $clog2(STORE_DEPTH);
    localparam int LOAD_W  = ADDR_W + 1;
    localparam int NROW_W  = ROW_W + 1;
    localparam int NCOL_W  = COL_W + 1;
    localparam int NCL_W   = CL_W + 1;
    localparam int FEAT_W  = 16;
    localparam int DIFF_W  = FEAT_W + 1;
    localparam int PROD_W  = 2 * FEAT_W;
    localparam int DIST_W  = PROD_W + COL_W;
    localparam int SUM_W   = FEAT_W + ROW_W;
    localparam int CNT_W   = ROW_W + 1;
    localparam int DIV_STEPS = SUM_W;
    localparam int DIVC_W  = $clog2(DIV_STEPS);
    localparam int ITER_W  = 8;

    // configuration register indexes
    localparam logic [1:0] CFG_NUM_CLUSTERS   = 2'd0;
    localparam logic [1:0] CFG_MAX_ITERATIONS = 2'd1;
    localparam logic [1:0] CFG_NUM_COLS       = 2'd2;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_NO_ROW   = 2'd1;
    localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

    localparam logic [3:0]        NUM_CLUSTERS_RST = 4'd3;
    localparam logic [ITER_W-1:0] MAX_ITER_RST     = 8'd15;
    localparam logic [ITER_W-1:0] ITER_DEFAULT     = 8'd10;
    localparam logic [4:0]        NUM_COLS_RST     = 5'd8;

    typedef struct packed {
        logic signed [FEAT_W-1:0] feature_value;
        logic                     last_value;
    } in_item_t;

    typedef struct packed {
        logic [CL_W-1:0]  cluster_id;
        logic [ROW_W-1:0] row_index;
        logic             last_row;
        logic [1:0]       status;
    } out_item_t;

    typedef enum logic [4:0] {
        ST_LOAD, ST_SETUP, ST_CHECK, ST_ROWS,
        ST_COPY_RD, ST_COPY_WR,
        ST_A_RD, ST_A_MUL, ST_A_ACC, ST_A_CMP, ST_A_WR,
        ST_U_RD, ST_U_ACC, ST_U_DIV_INIT, ST_U_DIV, ST_U_WR, ST_U_NEXT,
        ST_ROUND, ST_O_RD, ST_O_LOAD, ST_O_WAIT, ST_DONE
    } ctl_state_t;

    typedef enum logic [4:0] {
        OP_NOP, OP_STORE, OP_SETUP, OP_ERR_OVF, OP_ERR_NOROW, OP_ROW_STEP,
        OP_COPY_INIT, OP_COPY_WR,
        OP_A_MUL, OP_A_ACC, OP_A_CMP, OP_A_WR,
        OP_U_ACC, OP_DIV_INIT, OP_DIV_STEP, OP_U_WR, OP_U_NEXT,
        OP_ROUND, OP_O_LOAD, OP_O_NEXT, OP_CLEAR
    } dp_op_t;

    typedef struct packed {
        logic overflow_err;
        logic rem_ge_cols;
        logic rows_zero;
        logic j_last;
        logic c_last;
        logic r_last;
        logic cnt_zero;
        logic div_last;
        logic changed;
        logic iter_last;
        logic out_last;
    } dp_status_t;

endpackage

`default_nettype wire

// File: rtl/kmeans_cluster_assign_core.sv
// ---------------------------------------------------------------------------
// kmeans_cluster_assign_core
// lloyd k-means over a loaded block of q8.8 rows, one cluster id per row out
// ---------------------------------------------------------------------------
//  channel   ports                        moves
//  input     s_valid s_ready s_data       one feature value, last flag
//  result    m_valid m_ready m_data       cluster id, row, last, status
//  config    cfg_we cfg_index cfg_wdata   k, iteration limit, columns
//
//  loading accepts one item per cycle; the item with the last flag starts the job
//  job: row count, centroid copy, then rounds of an assign pass and an update
//  pass, using the single shared squarer, sample port and serial divider
//  results: each held until m_ready; no items taken during a job
//  reset: synchronous, active low; no clearing pass
// ---------------------------------------------------------------------------
`default_nettype none

module kmeans_cluster_assign_core (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire kca_pkg::in_item_t   s_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output kca_pkg::out_item_t       m_data,
    input  wire logic                cfg_we,
    input  wire logic [1:0]          cfg_index,
    input  wire logic [7:0]          cfg_wdata
);
    import kca_pkg::*;

    dp_op_t     op;
    dp_status_t st;

    kca_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_last  (s_data.last_value),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .st      (st),
        .op      (op)
    );

    kca_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .op        (op),
        .st        (st),
        .m_data    (m_data)
    );

endmodule

`default_nettype wire

// File: rtl/kca_datapath.sv
// ---------------------------------------------------------------------------
// kca_datapath
// sample, centroid and assignment stores, loop counters, distance unit,
// cluster accumulator, serial divider and result register
// ---------------------------------------------------------------------------
`default_nettype none

module kca_datapath (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire kca_pkg::in_item_t  s_data,
    input  wire logic               cfg_we,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [7:0]         cfg_wdata,
    input  wire kca_pkg::dp_op_t    op,
    output kca_pkg::dp_status_t     st,
    output kca_pkg::out_item_t      m_data
);
    import kca_pkg::*;

    // memories
    logic signed [FEAT_W-1:0] sample_mem [STORE_DEPTH];
    logic signed [FEAT_W-1:0] centroid_mem [CEN_DEPTH];
    logic [CL_W-1:0]          assign_mem [MAX_ROWS];

    logic [3:0]        num_clusters_reg;
    logic [ITER_W-1:0] max_iter_reg;
    logic [4:0]        num_cols_reg;
    logic [LOAD_W-1:0] load_cnt_reg;
    logic              overflow_reg;

    logic [NCOL_W-1:0] cols_reg;
    logic [LOAD_W-1:0] rem_reg;
    logic [NROW_W-1:0] rows_reg;
    logic [NCL_W-1:0]  k_reg;
    logic [ITER_W-1:0] iters_reg;
    logic [ITER_W-1:0] it_reg;
    logic              first_reg;
    logic              changed_reg;
    logic [ROW_W-1:0]  r_reg;
    logic [CL_W-1:0]   c_reg;
    logic [COL_W-1:0]  j_reg;
    logic [ADDR_W-1:0] rb_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [DIST_W-1:0] dist_reg;
    logic [DIST_W-1:0] best_reg;
    logic [CL_W-1:0]   best_c_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [SUM_W-1:0]  div_q_reg;
    logic [CNT_W-1:0]  div_rem_reg;
    logic [DIVC_W-1:0] div_cnt_reg;
    logic              div_neg_reg;
    out_item_t         out_reg;

    logic signed [FEAT_W-1:0] sample_rd_reg;
    logic signed [FEAT_W-1:0] cen_rd_reg;
    logic [CL_W-1:0]          assign_rd_reg;

    logic [ADDR_W-1:0]        samp_addr;
    logic [CL_W+COL_W-1:0]    cen_addr;
    logic                     load_full;
    logic [NCOL_W-1:0]        cols_eff;
    logic [NCL_W-1:0]         k_clamp;
    logic [ITER_W-1:0]        iters_eff;
    logic signed [DIFF_W-1:0] diff;
    logic signed [2*DIFF_W-1:0] sq;
    logic [DIST_W-1:0]        dist_sum;
    logic [CNT_W:0]           div_sh;
    logic                     div_bit;
    logic [SUM_W-1:0]         sum_abs;
    logic [SUM_W-1:0]         quot;
    logic [CL_W-1:0]          old_c;
    logic                     next_row_last;

    assign samp_addr = rb_reg + ADDR_W'(j_reg);
    assign cen_addr  = {c_reg, j_reg};
    assign load_full = (load_cnt_reg == LOAD_W'(STORE_DEPTH));

    always_comb begin
        if (num_cols_reg == '0) begin
            cols_eff = NCOL_W'(1);
        end else if (num_cols_reg > 5'(MAX_COLS)) begin
            cols_eff = NCOL_W'(MAX_COLS);
        end else begin
            cols_eff = NCOL_W'(num_cols_reg);
        end
        if (num_clusters_reg == '0) begin
            k_clamp = NCL_W'(1);
        end else if (num_clusters_reg > 4'(MAX_CLUSTERS)) begin
            k_clamp = NCL_W'(MAX_CLUSTERS);
        end else begin
            k_clamp = NCL_W'(num_clusters_reg);
        end
        iters_eff = (max_iter_reg == '0) ? ITER_DEFAULT : max_iter_reg;
    end

    assign diff     = DIFF_W'(sample_rd_reg) - DIFF_W'(cen_rd_reg);
    assign sq       = diff * diff;
    assign dist_sum = dist_reg + DIST_W'(prod_reg);
    assign div_sh   = {div_rem_reg, div_q_reg[SUM_W-1]};
    assign div_bit  = (div_sh >= {1'b0, cnt_reg});
    assign sum_abs  = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
    assign quot     = div_neg_reg ? (~div_q_reg + 1'b1) : div_q_reg;
    assign old_c    = first_reg ? '0 : assign_rd_reg;
    assign next_row_last = (NROW_W'(r_reg) == rows_reg - 1'b1);

    always_comb begin
        st.overflow_err = overflow_reg || (load_cnt_reg > {cols_reg, 6'b0});
        st.rem_ge_cols  = (rem_reg >= LOAD_W'(cols_reg));
        st.rows_zero    = (rows_reg == '0);
        st.j_last       = (NCOL_W'(j_reg) == cols_reg - 1'b1);
        st.c_last       = (NCL_W'(c_reg) == k_reg - 1'b1);
        st.r_last       = next_row_last;
        st.cnt_zero     = (cnt_reg == '0);
        st.div_last     = (div_cnt_reg == DIVC_W'(DIV_STEPS - 1));
        st.changed      = changed_reg;
        st.iter_last    = (it_reg == iters_reg - 1'b1);
        st.out_last     = out_reg.last_row;
    end

    assign m_data = out_reg;

    // memory ports
    always_ff @(posedge aclk) begin
        if (op == OP_STORE && !load_full) begin
            sample_mem[load_cnt_reg[ADDR_W-1:0]] <= s_data.feature_value;
        end
        sample_rd_reg <= sample_mem[samp_addr];
    end

    always_ff @(posedge aclk) begin
        if (op == OP_COPY_WR) begin
            centroid_mem[cen_addr] <= sample_rd_reg;
        end else if (op == OP_U_WR) begin
            centroid_mem[cen_addr] <= quot[FEAT_W-1:0];
        end
        cen_rd_reg <= centroid_mem[cen_addr];
    end

    always_ff @(posedge aclk) begin
        if (op == OP_A_WR) begin
            assign_mem[r_reg] <= best_c_reg;
        end
        assign_rd_reg <= assign_mem[r_reg];
    end

    // configuration and load bookkeeping
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_clusters_reg <= NUM_CLUSTERS_RST;
            max_iter_reg     <= MAX_ITER_RST;
            num_cols_reg     <= NUM_COLS_RST;
            load_cnt_reg     <= '0;
            overflow_reg     <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_NUM_CLUSTERS:   num_clusters_reg <= cfg_wdata[3:0];
                    CFG_MAX_ITERATIONS: max_iter_reg     <= cfg_wdata;
                    CFG_NUM_COLS:       num_cols_reg     <= cfg_wdata[4:0];
                    default: ;
                endcase
            end
            if (op == OP_STORE) begin
                if (load_full) begin
                    overflow_reg <= 1'b1;
                end else begin
                    load_cnt_reg <= load_cnt_reg + 1'b1;
                end
            end else if (op == OP_CLEAR) begin
                load_cnt_reg <= '0;
                overflow_reg <= 1'b0;
            end
        end
    end

    // job datapath
    always_ff @(posedge aclk) begin
        case (op)
            OP_SETUP: begin
                cols_reg <= cols_eff;
                rem_reg  <= load_cnt_reg;
                rows_reg <= '0;
            end
            OP_ERR_OVF: begin
                out_reg <= '{cluster_id: '0, row_index: '0, last_row: 1'b1,
                             status: STATUS_OVERFLOW};
            end
            OP_ERR_NOROW: begin
                out_reg <= '{cluster_id: '0, row_index: '0, last_row: 1'b1,
                             status: STATUS_NO_ROW};
            end
            OP_ROW_STEP: begin
                rem_reg  <= rem_reg - LOAD_W'(cols_reg);
                rows_reg <= rows_reg + 1'b1;
            end
            OP_COPY_INIT: begin
                k_reg     <= (NROW_W'(k_clamp) > rows_reg) ? NCL_W'(rows_reg) : k_clamp;
                iters_reg <= iters_eff;
                c_reg     <= '0;
                j_reg     <= '0;
                rb_reg    <= '0;
            end
            OP_COPY_WR: begin
                if (st.j_last && st.c_last) begin
                    // copy done, set up the first round
                    first_reg   <= 1'b1;
                    it_reg      <= '0;
                    changed_reg <= 1'b0;
                    r_reg       <= '0;
                    c_reg       <= '0;
                    j_reg       <= '0;
                    rb_reg      <= '0;
                    dist_reg    <= '0;
                end else if (st.j_last) begin
                    j_reg  <= '0;
                    c_reg  <= c_reg + 1'b1;
                    rb_reg <= rb_reg + ADDR_W'(cols_reg);
                end else begin
                    j_reg <= j_reg + 1'b1;
                end
            end
            OP_A_MUL: begin
                prod_reg <= sq[PROD_W-1:0];
            end
            OP_A_ACC: begin
                dist_reg <= dist_sum;
                if (!st.j_last) begin
                    j_reg <= j_reg + 1'b1;
                end
            end
            OP_A_CMP: begin
                if (c_reg == '0 || dist_reg < best_reg) begin
                    best_reg   <= dist_reg;
                    best_c_reg <= c_reg;
                end
                if (!st.c_last) begin
                    c_reg    <= c_reg + 1'b1;
                    j_reg    <= '0;
                    dist_reg <= '0;
                end
            end
            OP_A_WR: begin
                if (old_c != best_c_reg) begin
                    changed_reg <= 1'b1;
                end
                c_reg    <= '0;
                j_reg    <= '0;
                dist_reg <= '0;
                if (st.r_last) begin
                    r_reg   <= '0;
                    rb_reg  <= '0;
                    sum_reg <= '0;
                    cnt_reg <= '0;
                end else begin
                    r_reg  <= r_reg + 1'b1;
                    rb_reg <= rb_reg + ADDR_W'(cols_reg);
                end
            end
            OP_U_ACC: begin
                if (assign_rd_reg == c_reg) begin
                    sum_reg <= sum_reg + SUM_W'(sample_rd_reg);
                    cnt_reg <= cnt_reg + 1'b1;
                end
                if (!st.r_last) begin
                    r_reg  <= r_reg + 1'b1;
                    rb_reg <= rb_reg + ADDR_W'(cols_reg);
                end
            end
            OP_DIV_INIT: begin
                div_q_reg   <= sum_abs;
                div_rem_reg <= '0;
                div_cnt_reg <= '0;
                div_neg_reg <= sum_reg[SUM_W-1];
            end
            OP_DIV_STEP: begin
                div_rem_reg <= div_bit ? CNT_W'(div_sh - {1'b0, cnt_reg}) : div_sh[CNT_W-1:0];
                div_q_reg   <= {div_q_reg[SUM_W-2:0], div_bit};
                div_cnt_reg <= div_cnt_reg + 1'b1;
            end
            OP_U_NEXT: begin
                r_reg   <= '0;
                rb_reg  <= '0;
                sum_reg <= '0;
                cnt_reg <= '0;
                if (st.j_last) begin
                    j_reg <= '0;
                    c_reg <= c_reg + 1'b1;
                end else begin
                    j_reg <= j_reg + 1'b1;
                end
            end
            OP_ROUND: begin
                it_reg      <= it_reg + 1'b1;
                first_reg   <= 1'b0;
                changed_reg <= 1'b0;
                r_reg       <= '0;
                c_reg       <= '0;
                j_reg       <= '0;
                rb_reg      <= '0;
                dist_reg    <= '0;
            end
            OP_O_LOAD: begin
                out_reg <= '{cluster_id: assign_rd_reg, row_index: r_reg,
                             last_row: next_row_last, status: STATUS_OK};
            end
            OP_O_NEXT: begin
                r_reg <= r_reg + 1'b1;
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/kca_ctrl.sv
// ---------------------------------------------------------------------------
// kca_ctrl
// job sequencer: load, row count, centroid copy, assign and update rounds,
// result delivery
// ---------------------------------------------------------------------------
`default_nettype none

`include "kmeans_cluster_assign_core_defines.svh"

module kca_ctrl (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    input  wire logic                 s_last,
    output logic                      s_ready,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    input  wire kca_pkg::dp_status_t  st,
    output kca_pkg::dp_op_t           op
);
    import kca_pkg::*;

    ctl_state_t state_reg;
    ctl_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        op         = OP_NOP;
        s_ready    = 1'b0;
        m_valid    = 1'b0;
        case (state_reg)
            ST_LOAD: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    op = OP_STORE;
                    if (s_last) begin
                        state_next = ST_SETUP;
                    end
                end
            end
            ST_SETUP: begin
                op         = OP_SETUP;
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                if (st.overflow_err) begin
                    op         = OP_ERR_OVF;
                    state_next = ST_O_WAIT;
                end else begin
                    state_next = ST_ROWS;
                end
            end
            ST_ROWS: begin
                // rows = load count / cols by repeated subtraction
                if (st.rem_ge_cols) begin
                    op = OP_ROW_STEP;
                end else if (st.rows_zero) begin
                    op         = OP_ERR_NOROW;
                    state_next = ST_O_WAIT;
                end else begin
                    op         = OP_COPY_INIT;
                    state_next = ST_COPY_RD;
                end
            end
            ST_COPY_RD: state_next = ST_COPY_WR;
            ST_COPY_WR: begin
                op         = OP_COPY_WR;
                state_next = (st.j_last && st.c_last) ? ST_A_RD : ST_COPY_RD;
            end
            ST_A_RD: state_next = ST_A_MUL;
            ST_A_MUL: begin
                op         = OP_A_MUL;
                state_next = ST_A_ACC;
            end
            ST_A_ACC: begin
                op         = OP_A_ACC;
                state_next = st.j_last ? ST_A_CMP : ST_A_RD;
            end
            ST_A_CMP: begin
                op         = OP_A_CMP;
                state_next = st.c_last ? ST_A_WR : ST_A_RD;
            end
            ST_A_WR: begin
                op         = OP_A_WR;
                state_next = st.r_last ? ST_U_RD : ST_A_RD;
            end
            ST_U_RD: state_next = ST_U_ACC;
            ST_U_ACC: begin
                op         = OP_U_ACC;
                state_next = st.r_last ? ST_U_DIV_INIT : ST_U_RD;
            end
            ST_U_DIV_INIT: begin
                // empty cluster keeps its centroid
                if (st.cnt_zero) begin
                    state_next = ST_U_NEXT;
                end else begin
                    op         = OP_DIV_INIT;
                    state_next = ST_U_DIV;
                end
            end
            ST_U_DIV: begin
                op = OP_DIV_STEP;
                if (st.div_last) begin
                    state_next = ST_U_WR;
                end
            end
            ST_U_WR: begin
                op         = OP_U_WR;
                state_next = ST_U_NEXT;
            end
            ST_U_NEXT: begin
                op         = OP_U_NEXT;
                state_next = (st.j_last && st.c_last) ? ST_ROUND : ST_U_RD;
            end
            ST_ROUND: begin
                op         = OP_ROUND;
                state_next = (!st.changed || st.iter_last) ? ST_O_RD : ST_A_RD;
            end
            ST_O_RD: state_next = ST_O_LOAD;
            ST_O_LOAD: begin
                op         = OP_O_LOAD;
                state_next = ST_O_WAIT;
            end
            ST_O_WAIT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    if (st.out_last) begin
                        state_next = ST_DONE;
                    end else begin
                        op         = OP_O_NEXT;
                        state_next = ST_O_RD;
                    end
                end
            end
            ST_DONE: begin
                op         = OP_CLEAR;
                state_next = ST_LOAD;
            end
            default: state_next = ST_LOAD;
        endcase
    end

    `KCA_ASSERT_NOW(a_no_overlap, aclk, aresetn, s_ready, !m_valid, "load and delivery overlap")
    `KCA_ASSERT_NEXT(a_div_to_wr, aclk, aresetn, (state_reg == ST_U_DIV) && st.div_last, state_reg == ST_U_WR, "divider end missed")
    `KCA_ASSERT_NEXT(a_last_done, aclk, aresetn, m_valid && m_ready && st.out_last, state_reg == ST_DONE, "job end missed")
    `KCA_ASSERT_NEXT(a_done_load, aclk, aresetn, state_reg == ST_DONE, s_ready, "not back to load")

endmodule

`default_nettype wire
